// File: design/gccs_pkg.sv
package gccs_pkg;

  // field widths fixed by the word formats
  localparam int PIX_W      = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  // defaults for the top level parameters
  localparam int MAX_GRID_DIM_DEF = 16;

  // pixels at or beyond this coordinate are dropped
  localparam int MAX_IMAGE_SIDE = 1024;

  // register reset values
  localparam logic [9:0] CELL_WIDTH_RST  = 10'd50;
  localparam logic [9:0] CELL_HEIGHT_RST = 10'd50;
  localparam logic [4:0] GRID_COLS_RST   = 5'd10;
  localparam logic [4:0] GRID_ROWS_RST   = 5'd10;
  localparam logic [8:0] WIN_HALF_W_RST  = 9'd8;
  localparam logic [8:0] WIN_HALF_H_RST  = 9'd8;
  localparam logic [7:0] SAT_FLOOR_RST   = 8'd50;
  localparam logic [7:0] BRI_FLOOR_RST   = 8'd50;

  // hue bands, two-degree units (hue halved)
  localparam logic [7:0] HUE_RED_LOW_END    = 8'd10;
  localparam logic [7:0] HUE_RED_HIGH_START = 8'd160;
  localparam logic [7:0] HUE_TOP            = 8'd180;
  localparam logic [7:0] HUE_GREEN_START    = 8'd35;
  localparam logic [7:0] HUE_GREEN_END      = 8'd85;
  localparam logic [7:0] HUE_BLUE_START     = 8'd90;
  localparam logic [7:0] HUE_BLUE_END       = 8'd130;

  typedef enum logic [2:0] {
    COL_NONE  = 3'd0,
    COL_RED   = 3'd1,
    COL_GREEN = 3'd2,
    COL_BLUE  = 3'd3,
    COL_OTHER = 3'd4
  } colour_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH  = 3'd0,
    REG_CELL_HEIGHT = 3'd1,
    REG_GRID_COLS   = 3'd2,
    REG_GRID_ROWS   = 3'd3,
    REG_WIN_HALF_W  = 3'd4,
    REG_WIN_HALF_H  = 3'd5,
    REG_SAT_FLOOR   = 3'd6,
    REG_BRI_FLOOR   = 3'd7
  } cfg_reg_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       mask_set;
    logic       frame_last;
    logic [7:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic       frame_changed;
    logic [2:0] cell_colour;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_REPORT,
    ST_READ_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic cnt_clr;
    logic cnt_inc;
    logic clear_wr;
    logic lookup;
    logic update;
    logic sweep_rd;
    logic sweep_wr;
    logic load_read;
    logic load_report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_mode;
    logic div_done;
    logic cnt_last;
    logic frame_last;
    logic out_free;
  } ctrl_sts_t;

  function automatic colour_t classify(input logic [7:0] h, input logic [7:0] s,
                                       input logic [7:0] v, input logic [7:0] sat_floor,
                                       input logic [7:0] bri_floor);
    colour_t c;
    if (s < sat_floor || v < bri_floor) begin
      c = COL_NONE;
    end else if (h < HUE_RED_LOW_END || (h > HUE_RED_HIGH_START && h <= HUE_TOP)) begin
      c = COL_RED;
    end else if (h >= HUE_GREEN_START && h < HUE_GREEN_END) begin
      c = COL_GREEN;
    end else if (h >= HUE_BLUE_START && h < HUE_BLUE_END) begin
      c = COL_BLUE;
    end else begin
      c = COL_OTHER;
    end
    return c;
  endfunction

endpackage

// File: design/grid_cell_color_sampler_unit.sv
// grid cell colour sampler: takes HSV pixel words with a mask bit and x,y, finds the grid
// cell of each pixel by dividing by the cell size, and keeps the colour class (none, red,
// green, blue, other) of the first masked pixel inside the central window of each cell.
// a word with frame_last set is sampled, then every cell in use is compared with the
// stored grid and copied into it, and one report word says whether anything changed;
// the frame store is cleared in the same pass. a read word (mode 1) returns one stored
// cell. a pixel word goes through accept, a wait on the radix-4 dividers for column and
// row (five steps, then a check that both are done), a cell lookup and a frame store
// update; a read word or a frame end report waits for the output register; a frame end
// first sweeps the frame and grid memories (one read and one write port each), reading
// then writing each cell. no word is taken until the last one is done. after reset a
// clearing pass over all MAX_GRID_DIM^2 cells (256 by default) zeroes both memories
// before the first word is taken; configuration writes are taken at any time.
module grid_cell_color_sampler_unit #(
  parameter int MAX_GRID_DIM = gccs_pkg::MAX_GRID_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel / read words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gccs_pkg::in_word_t              in_data,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output gccs_pkg::out_word_t             out_data,
  // register writes
  input  logic                            cfg_we,
  input  logic [gccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gccs_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gccs_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: clearing pass, per-word steps, frame-end sweep
  gccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: registers, dividers, memories, output register
  gccs_dp #(.MAX_GRID_DIM(MAX_GRID_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: design/gccs_ram.sv
module gccs_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/gccs_div.sv
module gccs_div #(
  parameter int W = gccs_pkg::PIX_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);

  // restoring division, two quotient bits per cycle
  localparam int NCYC = (W + 1) / 2;
  localparam int QW   = 2 * NCYC;
  localparam int CW   = (NCYC > 1) ? $clog2(NCYC) : 1;

  logic [QW-1:0] quo_r, quo_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      rem_nxt = {rem_nxt[W-1:0], quo_nxt[QW-1]};
      quo_nxt = {quo_nxt[QW-2:0], 1'b0};
      if (rem_nxt >= {1'b0, div_r}) begin
        rem_nxt    = rem_nxt - {1'b0, div_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= QW'(dividend);
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(NCYC - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient  = quo_r[W-1:0];
  assign remainder = rem_r[W-1:0];
  assign done      = done_r;

endmodule

// File: design/gccs_ctrl.sv
module gccs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gccs_pkg::ctrl_sts_t sts,
  output gccs_pkg::ctrl_cmd_t cmd
);

  import gccs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_mode ? ST_READ_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.frame_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_SWEEP_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP_RD: begin
        cmd.sweep_rd = 1'b1;
        state_nxt    = ST_SWEEP_WR;
      end
      ST_SWEEP_WR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_REPORT;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = ST_SWEEP_RD;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.load_report = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_READ_OUT: begin
        if (sts.out_free) begin
          cmd.load_read = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: design/gccs_dp.sv
module gccs_dp #(
  parameter int MAX_GRID_DIM = gccs_pkg::MAX_GRID_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gccs_pkg::in_word_t                  in_data,
  output gccs_pkg::out_word_t                 out_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                cfg_we,
  input  logic [gccs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gccs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gccs_pkg::ctrl_cmd_t                 cmd,
  output gccs_pkg::ctrl_sts_t                 sts
);

  import gccs_pkg::*;

  localparam int NUM_CELLS = MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int IW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int DW        = $clog2(MAX_GRID_DIM + 1);
  localparam int KW        = 2 * DW;

  // configuration registers
  logic [9:0] cw_r, ch_r;
  logic [4:0] gc_r, gr_r;
  logic [8:0] whw_r, whh_r;
  logic [7:0] sf_r, bf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= CELL_WIDTH_RST;
      ch_r  <= CELL_HEIGHT_RST;
      gc_r  <= GRID_COLS_RST;
      gr_r  <= GRID_ROWS_RST;
      whw_r <= WIN_HALF_W_RST;
      whh_r <= WIN_HALF_H_RST;
      sf_r  <= SAT_FLOOR_RST;
      bf_r  <= BRI_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_WIDTH:  cw_r  <= cfg_data;
        REG_CELL_HEIGHT: ch_r  <= cfg_data;
        REG_GRID_COLS:   gc_r  <= cfg_data[4:0];
        REG_GRID_ROWS:   gr_r  <= cfg_data[4:0];
        REG_WIN_HALF_W:  whw_r <= cfg_data[8:0];
        REG_WIN_HALF_H:  whh_r <= cfg_data[8:0];
        REG_SAT_FLOOR:   sf_r  <= cfg_data[7:0];
        REG_BRI_FLOOR:   bf_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // grid size, clamped to the storage
  logic [DW-1:0] cols, rows;
  logic [KW-1:0] used;

  assign cols = (32'(gc_r) > MAX_GRID_DIM) ? DW'(MAX_GRID_DIM) : DW'(gc_r);
  assign rows = (32'(gr_r) > MAX_GRID_DIM) ? DW'(MAX_GRID_DIM) : DW'(gr_r);
  assign used = KW'(cols) * KW'(rows);

  // latched input word
  in_word_t in_r;
  logic     idx_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r     <= in_data;
      idx_ok_r <= (32'(in_data.cell_index) < NUM_CELLS);
    end
  end

  // column and row by division
  logic [PIX_W-1:0] col_q, col_rem, row_q, row_rem;
  logic             dx_done, dy_done;

  gccs_div #(.W(PIX_W)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.accept),
    .dividend  (in_data.pixel_x),
    .divisor   (cw_r),
    .quotient  (col_q),
    .remainder (col_rem),
    .done      (dx_done)
  );

  gccs_div #(.W(PIX_W)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.accept),
    .dividend  (in_data.pixel_y),
    .divisor   (ch_r),
    .quotient  (row_q),
    .remainder (row_rem),
    .done      (dy_done)
  );

  // hit test: offset from the cell centre is |remainder - size/2|
  logic [9:0]    half_cw, half_ch, off_x, off_y;
  logic          hit_nxt, hit_r;
  logic [KW-1:0] k_full;
  logic [IW-1:0] k_nxt, k_r;

  always_comb begin
    half_cw = cw_r >> 1;
    half_ch = ch_r >> 1;
    off_x   = (col_rem >= half_cw) ? col_rem - half_cw : half_cw - col_rem;
    off_y   = (row_rem >= half_ch) ? row_rem - half_ch : half_ch - row_rem;
    hit_nxt = in_r.mask_set
              && cw_r != '0 && ch_r != '0
              && 32'(in_r.pixel_x) < MAX_IMAGE_SIDE
              && 32'(in_r.pixel_y) < MAX_IMAGE_SIDE
              && 32'(col_q) < 32'(cols)
              && 32'(row_q) < 32'(rows)
              && off_x <= {1'b0, whw_r}
              && off_y <= {1'b0, whh_r};
    k_full  = KW'(row_q) * KW'(cols) + KW'(col_q);
    k_nxt   = IW'(k_full);
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r <= hit_nxt;
      k_r   <= k_nxt;
    end
  end

  // cell counter for the clearing pass and the frame-end sweep
  logic [IW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // frame store: found bit over colour
  logic          fr_we, fr_re;
  logic [IW-1:0] fr_waddr, fr_raddr;
  logic [3:0]    fr_wdata, fr_rdata;
  colour_t       pix_colour;

  assign pix_colour = classify(in_r.hue, in_r.saturation, in_r.brightness, sf_r, bf_r);
  assign fr_we      = cmd.clear_wr || cmd.sweep_wr || (cmd.update && hit_r && !fr_rdata[3]);
  assign fr_waddr   = cmd.update ? k_r : cnt_r;
  assign fr_wdata   = cmd.update ? {1'b1, pix_colour} : 4'd0;
  assign fr_re      = cmd.lookup || cmd.sweep_rd;
  assign fr_raddr   = cmd.lookup ? k_nxt : cnt_r;

  gccs_ram #(.WIDTH(4), .DEPTH(NUM_CELLS), .AW(IW)) u_frame_ram (
    .clk     (clk),
    .wr_en   (fr_we),
    .wr_addr (fr_waddr),
    .wr_data (fr_wdata),
    .rd_en   (fr_re),
    .rd_addr (fr_raddr),
    .rd_data (fr_rdata)
  );

  // stored grid
  logic          st_we, st_re, in_use;
  logic [IW-1:0] st_raddr;
  logic [2:0]    st_wdata, st_rdata;

  assign in_use   = KW'(cnt_r) < used;
  assign st_we    = cmd.clear_wr || (cmd.sweep_wr && in_use);
  assign st_wdata = cmd.clear_wr ? 3'(COL_NONE) : fr_rdata[2:0];
  assign st_re    = cmd.accept || cmd.sweep_rd;
  assign st_raddr = cmd.sweep_rd ? cnt_r : IW'(in_data.cell_index);

  gccs_ram #(.WIDTH(3), .DEPTH(NUM_CELLS), .AW(IW)) u_stored_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (cnt_r),
    .wr_data (st_wdata),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  logic changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      changed_r <= 1'b0;
    end else if (cmd.sweep_wr && in_use && st_rdata != fr_rdata[2:0]) begin
      changed_r <= 1'b1;
    end
  end

  // output register
  logic      out_valid_r;
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_read || cmd.load_report) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      out_r.result_kind   <= KIND_READ;
      out_r.frame_changed <= 1'b0;
      out_r.cell_colour   <= idx_ok_r ? st_rdata : 3'(COL_NONE);
    end else if (cmd.load_report) begin
      out_r.result_kind   <= KIND_REPORT;
      out_r.frame_changed <= changed_r;
      out_r.cell_colour   <= 3'(COL_NONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.in_mode    = in_data.mode;
  assign sts.div_done   = dx_done && dy_done;
  assign sts.cnt_last   = (cnt_r == IW'(NUM_CELLS - 1));
  assign sts.frame_last = in_r.frame_last;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// File: test/tb_grid_cell_color_sampler_unit.sv
module tb_grid_cell_color_sampler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gccs_pkg::*;

  localparam int NUM_CELLS       = MAX_GRID_DIM_DEF * MAX_GRID_DIM_DEF;
  localparam int PHASE_COUNT     = 10;
  localparam int WORDS_PER_PHASE = 95;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_OFF_CYCLES = 700;
  // lets a pixel word still in flight inside the block finish
  localparam int SETTLE_CYCLES   = 24;
  localparam int TAIL_CYCLES     = 32;
  // sized for the worst case, every word a frame end under the slowest drain
  localparam int RUN_LIMIT       = 3000000;

  // one full register setting of the sampler
  typedef struct packed {
    logic [9:0] cw;
    logic [9:0] ch;
    logic [4:0] cols;
    logic [4:0] rows;
    logic [8:0] hw;
    logic [8:0] hh;
    logic [7:0] sf;
    logic [7:0] bf;
  } grid_setting_t;

  // directed row: a word plus, where it is obvious, the answer typed in
  typedef struct packed {
    in_word_t  w;
    logic      fixed;
    out_word_t want;
  } stim_row_t;

  // stall shapes of the result side
  typedef enum {SHAPE_OPEN, SHAPE_COIN, SHAPE_COMB, SHAPE_TRICKLE} ready_shape_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // typed-in answer that travels with the word on the bus
  logic      row_fixed = 1'b0;
  out_word_t row_want  = '0;

  // shadow of the register file
  logic [9:0] cell_w    = CELL_WIDTH_RST;
  logic [9:0] cell_h    = CELL_HEIGHT_RST;
  logic [4:0] grid_cols = GRID_COLS_RST;
  logic [4:0] grid_rows = GRID_ROWS_RST;
  logic [8:0] half_w    = WIN_HALF_W_RST;
  logic [8:0] half_h    = WIN_HALF_H_RST;
  logic [7:0] sat_floor = SAT_FLOOR_RST;
  logic [7:0] bri_floor = BRI_FLOOR_RST;

  // our own copy of the frame store and the stored grid
  colour_t frame_cls [NUM_CELLS];
  bit      cell_hit  [NUM_CELLS];
  colour_t grid_cls  [NUM_CELLS];

  // answers owed by the block, oldest first
  out_word_t owed_answers [$];
  stim_row_t directed_rows [$];

  int          errors      = 0;
  int unsigned cycle_count = 0;
  int          frame_left  = 10;
  int          burst_left  = 0;
  bit          sender_steady = 1'b0;
  bit          hold_off_req  = 1'b0;

  grid_cell_color_sampler_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic int clamp_dim(input logic [4:0] d);
    return (int'(d) > MAX_GRID_DIM_DEF) ? MAX_GRID_DIM_DEF : int'(d);
  endfunction

  function automatic int abs_diff(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // hue bands are disjoint, so the order of the hue tests does not matter; the floor test comes last and wins
  function automatic colour_t hsv_class(input logic [7:0] h, input logic [7:0] s,
                                        input logic [7:0] v);
    colour_t c;
    c = COL_OTHER;
    if (h >= HUE_BLUE_START && h < HUE_BLUE_END) begin
      c = COL_BLUE;
    end
    if (h >= HUE_GREEN_START && h < HUE_GREEN_END) begin
      c = COL_GREEN;
    end
    if (h < HUE_RED_LOW_END || (h > HUE_RED_HIGH_START && h <= HUE_TOP)) begin
      c = COL_RED;
    end
    if (s < sat_floor || v < bri_floor) begin
      c = COL_NONE;
    end
    return c;
  endfunction

  // advance the shadow grid by one accepted word; returns 1 when it owes an answer
  function automatic bit colour_grid_step(input in_word_t w, output out_word_t r);
    int  cols, rows, x, y, c, rw, k, used;
    bit  changed;
    r = '0;
    if (w.mode) begin
      // read answer, pixel fields and frame_last play no part
      r.result_kind = KIND_READ;
      r.cell_colour = grid_cls[w.cell_index];
      return 1'b1;
    end
    cols = clamp_dim(grid_cols);
    rows = clamp_dim(grid_rows);
    x    = int'(w.pixel_x);
    y    = int'(w.pixel_y);
    // coordinates are 10 bits wide, so they never reach the image side limit
    if (w.mask_set && cell_w != 0 && cell_h != 0) begin
      c  = x / int'(cell_w);
      rw = y / int'(cell_h);
      if (c < cols && rw < rows &&
          abs_diff(x, c * int'(cell_w) + int'(cell_w) / 2) <= int'(half_w) &&
          abs_diff(y, rw * int'(cell_h) + int'(cell_h) / 2) <= int'(half_h)) begin
        k = rw * cols + c;
        // first qualifying pixel of the window wins
        if (k < NUM_CELLS && !cell_hit[k]) begin
          frame_cls[k] = hsv_class(w.hue, w.saturation, w.brightness);
          cell_hit[k]  = 1'b1;
        end
      end
    end
    if (!w.frame_last) begin
      return 1'b0;
    end
    // frame end: compare and copy the cells in use, then wipe the frame store
    used    = cols * rows;
    changed = 1'b0;
    for (k = 0; k < used; k++) begin
      if (grid_cls[k] != frame_cls[k]) begin
        changed = 1'b1;
      end
      grid_cls[k] = frame_cls[k];
    end
    for (k = 0; k < NUM_CELLS; k++) begin
      frame_cls[k] = COL_NONE;
      cell_hit[k]  = 1'b0;
    end
    r.result_kind   = KIND_REPORT;
    r.frame_changed = changed;
    r.cell_colour   = COL_NONE;
    return 1'b1;
  endfunction

  // scoreboard: check the result word first, then account for the accepted input
  always @(posedge clk) begin : scoreboard
    out_word_t want, got;
    bit        owes;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_answers.size() == 0) begin
          flag_mismatch($sformatf("unrequested word kind %0d changed %0d colour %0d",
                                  out_data.result_kind, out_data.frame_changed,
                                  out_data.cell_colour));
        end else begin
          want = owed_answers.pop_front();
          if (out_data.result_kind !== want.result_kind) begin
            flag_mismatch($sformatf("result_kind %0d, wanted %0d",
                                    out_data.result_kind, want.result_kind));
          end
          if (out_data.frame_changed !== want.frame_changed) begin
            flag_mismatch($sformatf("frame_changed %0d, wanted %0d",
                                    out_data.frame_changed, want.frame_changed));
          end
          if (out_data.cell_colour !== want.cell_colour) begin
            flag_mismatch($sformatf("cell_colour %0d, wanted %0d",
                                    out_data.cell_colour, want.cell_colour));
          end
        end
      end
      if (in_valid && in_ready) begin
        owes = colour_grid_step(in_data, got);
        // typed-in answers take the place of the computed one
        if (row_fixed) begin
          owed_answers.push_back(row_want);
        end else if (owes) begin
          owed_answers.push_back(got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: stretches of different stall shapes, plus one long hold-off on request
  initial begin : drain_side
    ready_shape_t shape;
    int           len, i;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (i = 0; i < HOLD_OFF_CYCLES; i++) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        shape = ready_shape_t'($urandom_range(3));
        len   = $urandom_range(150, 20);
        for (i = 0; i < len && !hold_off_req; i++) begin
          @(negedge clk);
          case (shape)
            SHAPE_OPEN:  out_ready <= 1'b1;
            SHAPE_COIN:  out_ready <= ($urandom_range(9) < 6);
            SHAPE_COMB:  out_ready <= (i % 4 != 3);
            default:     out_ready <= (i % 13 == 0);
          endcase
        end
      end
    end
  end

  // offer one word, hold it until taken, then maybe leave a gap after the burst
  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t want);
    int gap;
    in_data   <= w;
    in_valid  <= 1'b1;
    row_fixed <= fixed;
    row_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap        = $urandom_range(8);
      if (!sender_steady && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // stop offering and let everything owed come back
  task automatic drain_all();
    in_valid  <= 1'b0;
    row_fixed <= 1'b0;
    while (owed_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [9:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_CELL_WIDTH:  cell_w    = v;
      REG_CELL_HEIGHT: cell_h    = v;
      REG_GRID_COLS:   grid_cols = v[4:0];
      REG_GRID_ROWS:   grid_rows = v[4:0];
      REG_WIN_HALF_W:  half_w    = v[8:0];
      REG_WIN_HALF_H:  half_h    = v[8:0];
      REG_SAT_FLOOR:   sat_floor = v[7:0];
      default:         bri_floor = v[7:0];
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input grid_setting_t s);
    write_reg(REG_CELL_WIDTH, s.cw);
    write_reg(REG_CELL_HEIGHT, s.ch);
    write_reg(REG_GRID_COLS, 10'(s.cols));
    write_reg(REG_GRID_ROWS, 10'(s.rows));
    write_reg(REG_WIN_HALF_W, 10'(s.hw));
    write_reg(REG_WIN_HALF_H, 10'(s.hh));
    write_reg(REG_SAT_FLOOR, 10'(s.sf));
    write_reg(REG_BRI_FLOOR, 10'(s.bf));
    cfg_we <= 1'b0;
  endtask

  function automatic in_word_t pix(input int x, input int y, input int h, input int s,
                                   input int v, input bit m, input bit last);
    in_word_t w;
    w            = '0;
    w.pixel_x    = x[9:0];
    w.pixel_y    = y[9:0];
    w.hue        = h[7:0];
    w.saturation = s[7:0];
    w.brightness = v[7:0];
    w.mask_set   = m;
    w.frame_last = last;
    return w;
  endfunction

  function automatic in_word_t rd(input int idx);
    in_word_t w;
    w            = '0;
    w.mode       = 1'b1;
    w.cell_index = idx[7:0];
    return w;
  endfunction

  function automatic out_word_t read_ans(input colour_t c);
    out_word_t r;
    r             = '0;
    r.result_kind = KIND_READ;
    r.cell_colour = c;
    return r;
  endfunction

  function automatic out_word_t frame_ans(input bit changed);
    out_word_t r;
    r               = '0;
    r.result_kind   = KIND_REPORT;
    r.frame_changed = changed;
    return r;
  endfunction

  function automatic void add_row(input in_word_t w, input bit fixed, input out_word_t want);
    stim_row_t row;
    row.w     = w;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] roll_byte();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(1) ? 8'd255 : 8'd0;
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic grid_setting_t roll_setting();
    grid_setting_t s;
    s.cw   = 10'($urandom_range(64, 2));
    s.ch   = 10'($urandom_range(64, 2));
    s.cols = 5'(($urandom_range(4) == 0) ? $urandom_range(31, 17) : $urandom_range(16, 1));
    s.rows = 5'(($urandom_range(4) == 0) ? $urandom_range(31, 17) : $urandom_range(16, 1));
    // mostly what software writes, sometimes a window wider than the cell
    s.hw   = ($urandom_range(3) == 0) ? 9'($urandom_range(int'(s.cw)))
                                      : 9'((s.cw / 3) / 2 + $urandom_range(2));
    s.hh   = ($urandom_range(3) == 0) ? 9'($urandom_range(int'(s.ch)))
                                      : 9'((s.ch / 3) / 2 + $urandom_range(2));
    s.sf   = 8'($urandom_range(120));
    s.bf   = 8'($urandom_range(120));
    return s;
  endfunction

  // next random word: mostly pixels aimed at the windows, grouped into frames
  function automatic in_word_t next_random_word(output bit noise);
    in_word_t    w;
    logic [63:0] junk;
    int          roll, cols, rows, used, c, rw, vx, vy, span_x, span_y;
    junk  = {$urandom, $urandom};
    w     = junk[$bits(in_word_t)-1:0];
    noise = 1'b0;
    cols  = clamp_dim(grid_cols);
    rows  = clamp_dim(grid_rows);
    used  = cols * rows;
    roll  = $urandom_range(99);
    if (roll < 14) begin
      // cell read, pixel fields left as junk
      w.mode = 1'b1;
      if (used > 0 && $urandom_range(3) != 0) begin
        w.cell_index = 8'($urandom_range(used - 1));
      end
    end else if (roll < 22) begin
      // raw noise pixel, rarely closing a frame
      w.mode       = 1'b0;
      w.frame_last = ($urandom_range(15) == 0);
      noise        = !w.frame_last;
    end else begin
      // aim at a window, now and then one cell past the grid or just outside the window
      c      = $urandom_range(cols);
      rw     = $urandom_range(rows);
      span_x = int'(half_w) + 2;
      span_y = int'(half_h) + 2;
      vx = c * int'(cell_w) + int'(cell_w) / 2 + int'($urandom_range(2 * span_x)) - span_x;
      vy = rw * int'(cell_h) + int'(cell_h) / 2 + int'($urandom_range(2 * span_y)) - span_y;
      vx = (vx < 0) ? 0 : ((vx > 1023) ? 1023 : vx);
      vy = (vy < 0) ? 0 : ((vy > 1023) ? 1023 : vy);
      w.mode       = 1'b0;
      w.pixel_x    = vx[9:0];
      w.pixel_y    = vy[9:0];
      w.hue        = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(179));
      w.saturation = roll_byte();
      w.brightness = roll_byte();
      w.mask_set   = ($urandom_range(9) != 0);
      frame_left--;
      w.frame_last = (frame_left <= 0);
      if (frame_left <= 0) begin
        frame_left = $urandom_range(40, 4);
      end
    end
    return w;
  endfunction

  initial begin : stimulus
    grid_setting_t plan [PHASE_COUNT];
    in_word_t      w;
    bit            noise;
    int            p, n, k;

    for (k = 0; k < NUM_CELLS; k++) begin
      frame_cls[k] = COL_NONE;
      grid_cls[k]  = COL_NONE;
    end

    // extremes first, then the special settings, then random ones
    plan[0] = '{cw: 10'd1, ch: 10'd1, cols: 5'd16, rows: 5'd16,
                hw: 9'd0, hh: 9'd0, sf: 8'd0, bf: 8'd0};
    plan[1] = '{cw: 10'd1023, ch: 10'd1023, cols: 5'd31, rows: 5'd31,
                hw: 9'd511, hh: 9'd511, sf: 8'd255, bf: 8'd255};
    // zero cell width: pixels drop, frame ends still report
    plan[2] = '{cw: 10'd0, ch: 10'd30, cols: 5'd8, rows: 5'd8,
                hw: 9'd5, hh: 9'd5, sf: 8'd40, bf: 8'd40};
    // no columns in use
    plan[3] = '{cw: 10'd20, ch: 10'd20, cols: 5'd0, rows: 5'd6,
                hw: 9'd3, hh: 9'd3, sf: 8'd50, bf: 8'd50};
    // windows wider than the cell, neighbours must not steal pixels
    plan[4] = '{cw: 10'd40, ch: 10'd24, cols: 5'd16, rows: 5'd12,
                hw: 9'd30, hh: 9'd20, sf: 8'd30, bf: 8'd30};
    for (p = 5; p < PHASE_COUNT; p++) begin
      plan[p] = roll_setting();
    end

    // directed words under the reset setting (50x50 cells, 10x10 grid, window +/-8)
    add_row(rd(0), 1'b1, read_ans(COL_NONE));
    add_row(rd(255), 1'b1, read_ans(COL_NONE));
    add_row(pix(0, 0, 0, 0, 0, 1'b0, 1'b1), 1'b1, frame_ans(1'b0));
    add_row(pix(25, 25, 0, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    // same window again: the earlier red pixel keeps the cell
    add_row(pix(25, 25, 60, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    add_row(pix(75, 25, 60, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    add_row(pix(125, 25, 100, 200, 200, 1'b1, 1'b0), 1'b0, '0);
    add_row(pix(175, 25, 20, 200, 200, 1'b1, 1'b0), 1'b0, '0);
    // just under the saturation and brightness floors
    add_row(pix(225, 25, 60, 49, 255, 1'b1, 1'b0), 1'b0, '0);
    add_row(pix(275, 25, 60, 255, 49, 1'b1, 1'b0), 1'b0, '0);
    // upper red band, exactly at the floors
    add_row(pix(325, 25, 179, 50, 50, 1'b1, 1'b0), 1'b0, '0);
    // hue beyond 180
    add_row(pix(375, 25, 255, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    // unmasked pixel must not claim the cell
    add_row(pix(425, 25, 60, 255, 255, 1'b0, 1'b0), 1'b0, '0);
    add_row(pix(433, 25, 60, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    // far corner lies outside the grid
    add_row(pix(1023, 1023, 100, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    // one past the window edge, then right on it
    add_row(pix(25, 84, 100, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    add_row(pix(17, 67, 35, 255, 255, 1'b1, 1'b0), 1'b0, '0);
    // last pixel is sampled before the frame closes
    add_row(pix(25, 475, 40, 255, 255, 1'b1, 1'b1), 1'b1, frame_ans(1'b1));
    add_row(rd(0), 1'b1, read_ans(COL_RED));
    add_row(rd(3), 1'b1, read_ans(COL_OTHER));
    add_row(rd(10), 1'b1, read_ans(COL_GREEN));
    add_row(rd(8), 1'b1, read_ans(COL_GREEN));
    // read with every pixel field set and frame_last high
    w            = pix(1023, 1023, 255, 255, 255, 1'b1, 1'b1);
    w.mode       = 1'b1;
    w.cell_index = 8'd7;
    add_row(w, 1'b1, read_ans(COL_OTHER));
    add_row(pix(0, 0, 0, 0, 0, 1'b0, 1'b1), 1'b1, frame_ans(1'b1));
    add_row(pix(1023, 0, 0, 255, 255, 1'b1, 1'b1), 1'b1, frame_ans(1'b0));
    add_row(rd(90), 1'b1, read_ans(COL_NONE));

    // synchronous reset
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // the block runs its clearing pass first; the handshake simply waits it out
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].w, directed_rows[i].fixed, directed_rows[i].want);
    end

    for (p = 0; p < PHASE_COUNT; p++) begin
      // registers change only while the block is idle
      drain_all();
      repeat (SETTLE_CYCLES) @(negedge clk);
      apply_setting(plan[p]);
      sender_steady = ($urandom_range(2) == 0);
      if (p == PRESSURE_PHASE) begin
        // keep offering while the result side holds off, so the block backs up
        sender_steady = 1'b1;
        hold_off_req  = 1'b1;
      end
      n = 0;
      while (n < WORDS_PER_PHASE) begin
        w = next_random_word(noise);
        send_word(w, 1'b0, '0);
        if (!noise) begin
          n++;
        end
      end
    end

    drain_all();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/gccs_pkg.sv
design/gccs_ram.sv
design/gccs_div.sv
design/gccs_ctrl.sv
design/gccs_dp.sv
design/grid_cell_color_sampler_unit.sv
test/tb_grid_cell_color_sampler_unit.sv
